// ----- sv/ssed_pkg.sv -----
`timescale 1ns / 1ps

package ssed_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_WIDTH   = 2048;
    localparam int DEF_MAX_HEIGHT  = 4096;
    localparam int DEF_SAMPLE_BITS = 16;

    // Register reset values
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    // Register interface
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_WIDTH_BITS = 12;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Result field widths
    localparam int ROW_OUT_BITS = 12;
    localparam int COL_OUT_BITS = 11;

    // Depth of both queues (power of two)
    localparam int QUEUE_DEPTH = 4;

    // Window geometry: 3 layers x 3 rows per column
    localparam int LAYERS   = 3;
    localparam int COL_SAMP = 9;

    // A size of zero acts as one, above the maximum acts as the maximum
    function automatic int clamp_dim(input int v, input int maxv);
        int r;
        begin
            r = v;
            if (v == 0)
            begin
                r = 1;
            end
            else if (v > maxv)
            begin
                r = maxv;
            end
            return r;
        end
    endfunction

endpackage

// ----- sv/ssed_fifo.sv -----
`timescale 1ns / 1ps

module ssed_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ssed_pkg::QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           head_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PB = $clog2(DEPTH);
    localparam int CB = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PB-1:0]    wr_ptr_reg;
    logic [PB-1:0]    rd_ptr_reg;
    logic [CB-1:0]    count_reg;

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign head_data = mem[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// ----- sv/ssed_front.sv -----
`timescale 1ns / 1ps

module ssed_front #(
    parameter int MAX_WIDTH   = ssed_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = ssed_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = ssed_pkg::DEF_SAMPLE_BITS,
    parameter int CB = $clog2(MAX_WIDTH),
    parameter int WB = $clog2(MAX_WIDTH + 1),
    parameter int HB = $clog2(MAX_HEIGHT + 1),
    parameter int QW = ssed_pkg::COL_SAMP * SAMPLE_BITS + 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [WB-1:0]          w_cfg,
    input  logic [HB-1:0]          h_cfg,
    input  logic                   restart,
    input  logic                   take,
    input  logic                   mode,
    input  logic [SAMPLE_BITS-1:0] lower_sample,
    input  logic [SAMPLE_BITS-1:0] current_sample,
    input  logic [SAMPLE_BITS-1:0] upper_sample,
    output logic                   stage_valid,
    output logic                   q_push,
    output logic [QW-1:0]          q_data
);

    localparam int SB  = SAMPLE_BITS;
    localparam int LW  = ssed_pkg::LAYERS * SB;
    localparam int RB  = $clog2(MAX_HEIGHT + 2);

    // Line store: per column {newer line, older line}, three layers each
    logic [2*LW-1:0] line_mem [MAX_WIDTH];

    logic [RB-1:0]   in_row_reg;
    logic [CB-1:0]   in_col_reg;
    logic            s1_valid_reg;
    logic [CB-1:0]   s1_col_reg;
    logic [LW-1:0]   s1_fresh_reg;
    logic            s1_emit_reg;
    logic [2*LW-1:0] rd_data_reg;
    logic            lw_valid_reg;
    logic [CB-1:0]   lw_addr_reg;
    logic [2*LW-1:0] lw_data_reg;

    logic            in_frame;
    logic            flush_in_frame;
    logic            go;
    logic            emit;
    logic            last_item;
    logic [WB-1:0]   col_inc;
    logic [LW-1:0]   fresh;
    logic [2*LW-1:0] merged;
    logic [2*LW-1:0] wr_data;

    // Classify the incoming beat
    assign in_frame       = in_row_reg < RB'(h_cfg);
    assign flush_in_frame = mode && in_frame;
    assign go             = take && !flush_in_frame;
    assign emit           = (in_row_reg >= RB'(2)) ||
                            ((in_row_reg == RB'(1)) && (in_col_reg != '0));
    // The beat that yields the frame's last result also ends the frame
    assign last_item      = (in_row_reg == RB'(h_cfg) + RB'(1)) && (in_col_reg == '0);
    assign col_inc        = WB'(in_col_reg) + WB'(1);
    assign fresh          = in_frame ? {upper_sample, current_sample, lower_sample} : '0;

    // Input position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg <= '0;
            in_col_reg <= '0;
        end
        else if (restart)
        begin
            in_row_reg <= '0;
            in_col_reg <= '0;
        end
        else if (go)
        begin
            if (last_item)
            begin
                in_row_reg <= '0;
                in_col_reg <= '0;
            end
            else if (col_inc >= w_cfg)
            begin
                in_col_reg <= '0;
                in_row_reg <= in_row_reg + RB'(1);
            end
            else
            begin
                in_col_reg <= CB'(col_inc);
            end
        end
    end

    // Stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= go;
            if (s1_valid_reg)
            begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            s1_col_reg   <= in_col_reg;
            s1_fresh_reg <= fresh;
            s1_emit_reg  <= emit;
        end
        if (s1_valid_reg)
        begin
            lw_addr_reg <= s1_col_reg;
            lw_data_reg <= wr_data;
        end
    end

    // Line store read and write
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rd_data_reg <= line_mem[in_col_reg];
        end
        if (s1_valid_reg)
        begin
            line_mem[s1_col_reg] <= wr_data;
        end
    end

    // Forward the write made at the same edge as this read
    assign merged  = (lw_valid_reg && (lw_addr_reg == s1_col_reg)) ? lw_data_reg : rd_data_reg;
    assign wr_data = {s1_fresh_reg, merged[2*LW-1:LW]};

    // Column beat: {emit, fresh row, newer row, older row}
    assign stage_valid = s1_valid_reg;
    assign q_push      = s1_valid_reg;
    assign q_data      = {s1_emit_reg, s1_fresh_reg, merged[2*LW-1:LW], merged[LW-1:0]};

endmodule

// ----- sv/ssed_back.sv -----
`timescale 1ns / 1ps

module ssed_back #(
    parameter int MAX_WIDTH   = ssed_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = ssed_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = ssed_pkg::DEF_SAMPLE_BITS,
    parameter int CB = $clog2(MAX_WIDTH),
    parameter int WB = $clog2(MAX_WIDTH + 1),
    parameter int HB = $clog2(MAX_HEIGHT + 1),
    parameter int QW = ssed_pkg::COL_SAMP * SAMPLE_BITS + 1,
    parameter int OW = ssed_pkg::ROW_OUT_BITS + ssed_pkg::COL_OUT_BITS + 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [WB-1:0] w_cfg,
    input  logic [HB-1:0] h_cfg,
    input  logic          restart,
    input  logic          take,
    input  logic [QW-1:0] q_data,
    output logic          res_valid,
    output logic [OW-1:0] res_data
);

    localparam int SB  = SAMPLE_BITS;
    localparam int NS  = ssed_pkg::COL_SAMP;
    localparam int ORB = $clog2(MAX_HEIGHT);

    // Window: three columns, each 3 rows x 3 layers, index row*3 + layer
    logic signed [SB-1:0] win_reg [3][NS];
    logic [ORB-1:0]       out_row_reg;
    logic [CB-1:0]        out_col_reg;
    logic                 b2_valid_reg;
    logic [ORB-1:0]       b2_row_reg;
    logic [CB-1:0]        b2_col_reg;
    logic                 b2_done_reg;
    logic [2:0]           row_ok_reg;
    logic [2:0]           col_ok_reg;

    logic                 emit;
    logic                 done;
    logic                 col_last;
    logic                 row_last;
    logic signed [SB-1:0] center;
    logic                 any_gt;
    logic                 any_lt;

    assign emit     = take && q_data[QW-1];
    assign col_last = (WB'(out_col_reg) + WB'(1)) == w_cfg;
    assign row_last = (HB'(out_row_reg) + HB'(1)) == h_cfg;
    assign done     = col_last && row_last;

    // Shift the window one column per beat
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int s = 0; s < NS; s++)
            begin
                win_reg[0][s] <= win_reg[1][s];
                win_reg[1][s] <= win_reg[2][s];
                win_reg[2][s] <= q_data[s*SB +: SB];
            end
        end
    end

    // Output position counters and the judge stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            b2_valid_reg <= 1'b0;
        end
        else if (restart)
        begin
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            b2_valid_reg <= 1'b0;
        end
        else
        begin
            b2_valid_reg <= emit;
            if (emit)
            begin
                if (done)
                begin
                    out_row_reg <= '0;
                    out_col_reg <= '0;
                end
                else if (col_last)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + ORB'(1);
                end
                else
                begin
                    out_col_reg <= out_col_reg + CB'(1);
                end
            end
        end
    end

    // Clipping masks for the judged center
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            b2_row_reg  <= out_row_reg;
            b2_col_reg  <= out_col_reg;
            b2_done_reg <= done;
            row_ok_reg  <= {!row_last, 1'b1, out_row_reg != '0};
            col_ok_reg  <= {!col_last, 1'b1, out_col_reg != '0};
        end
    end

    // Compare every neighbour in the clipped window against the center
    assign center = win_reg[1][4];

    always_comb
    begin
        any_gt = 1'b0;
        any_lt = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            for (int s = 0; s < NS; s++)
            begin
                if (col_ok_reg[k] && row_ok_reg[s / 3])
                begin
                    if (win_reg[k][s] > center)
                    begin
                        any_gt = 1'b1;
                    end
                    if (win_reg[k][s] < center)
                    begin
                        any_lt = 1'b1;
                    end
                end
            end
        end
    end

    assign res_valid = b2_valid_reg;
    assign res_data  = {ssed_pkg::ROW_OUT_BITS'(b2_row_reg),
                        ssed_pkg::COL_OUT_BITS'(b2_col_reg),
                        !any_gt || !any_lt,
                        b2_done_reg};

endmodule

// ----- sv/scale_space_extremum_detector.sv -----
`timescale 1ns / 1ps

// 3x3x3 difference-of-Gaussian extremum detector. Push one co-located
// (lower, current, upper) Q8.8 sample triple per clock in raster order; the
// block sustains one item per clock while full stays low, limited by the single
// read-modify-write of the line store column per item. A result for pixel
// (r, c) appears after the item one line plus one pixel later has been
// pushed; after the last pixel of a frame push frame_width + 1 flush items
// (mode = 1) to drain it. Flush items inside the frame are ignored.
// A plateau counts as an extremum, and neighbours outside the frame are left
// out of the comparison. Write frame_width and frame_height only while idle;
// a write restarts the frame. The line store needs no clearing after reset.
module scale_space_extremum_detector #(
    parameter int MAX_WIDTH   = ssed_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = ssed_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = ssed_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [ssed_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [ssed_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  mode,
    input  logic signed [SAMPLE_BITS-1:0]         lower_sample,
    input  logic signed [SAMPLE_BITS-1:0]         current_sample,
    input  logic signed [SAMPLE_BITS-1:0]         upper_sample,
    output logic                                  empty,
    input  logic                                  pop,
    output logic [ssed_pkg::ROW_OUT_BITS-1:0]     pixel_row,
    output logic [ssed_pkg::COL_OUT_BITS-1:0]     pixel_col,
    output logic                                  is_extremum,
    output logic                                  frame_done
);

    localparam int CB    = $clog2(MAX_WIDTH);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int HB    = $clog2(MAX_HEIGHT + 1);
    localparam int QW    = ssed_pkg::COL_SAMP * SAMPLE_BITS + 1;
    localparam int OW    = ssed_pkg::ROW_OUT_BITS + ssed_pkg::COL_OUT_BITS + 2;
    localparam int DEPTH = ssed_pkg::QUEUE_DEPTH;
    localparam int FB    = $clog2(DEPTH + 1);
    localparam int ROWB  = ssed_pkg::ROW_OUT_BITS;
    localparam int COLB  = ssed_pkg::COL_OUT_BITS;

    localparam logic [WB-1:0] W_RESET =
        WB'(ssed_pkg::clamp_dim(ssed_pkg::WIDTH_RESET, MAX_WIDTH));
    localparam logic [HB-1:0] H_RESET =
        HB'(ssed_pkg::clamp_dim(ssed_pkg::HEIGHT_RESET, MAX_HEIGHT));

    logic [WB-1:0] w_reg;
    logic [HB-1:0] h_reg;

    logic          accept;
    logic          stage_valid;
    logic          mq_push;
    logic [QW-1:0] mq_push_data;
    logic [QW-1:0] mq_head;
    logic [FB-1:0] mq_count;
    logic          mq_pop;
    logic          res_valid;
    logic [OW-1:0] res_data;
    logic [OW-1:0] oq_head;
    logic [FB-1:0] oq_count;
    logic          oq_pop;

    // Configuration registers, clamped as written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= W_RESET;
            h_reg <= H_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ssed_pkg::REG_FRAME_WIDTH:
                begin
                    w_reg <= WB'(ssed_pkg::clamp_dim(
                        int'(cfg_data[ssed_pkg::CFG_WIDTH_BITS-1:0]), MAX_WIDTH));
                end
                ssed_pkg::REG_FRAME_HEIGHT:
                begin
                    h_reg <= HB'(ssed_pkg::clamp_dim(int'(cfg_data), MAX_HEIGHT));
                end
                default:
                begin
                end
            endcase
        end
    end

    // Space is reserved for the beat already in the line store stage
    assign full   = (FB'(mq_count) + FB'(stage_valid)) >= FB'(DEPTH);
    assign accept = push && !full;

    ssed_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CB          (CB),
        .WB          (WB),
        .HB          (HB),
        .QW          (QW)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .w_cfg          (w_reg),
        .h_cfg          (h_reg),
        .restart        (cfg_write),
        .take           (accept),
        .mode           (mode),
        .lower_sample   (lower_sample),
        .current_sample (current_sample),
        .upper_sample   (upper_sample),
        .stage_valid    (stage_valid),
        .q_push         (mq_push),
        .q_data         (mq_push_data)
    );

    ssed_fifo #(
        .WIDTH (QW),
        .DEPTH (DEPTH)
    ) u_mid_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mq_push),
        .push_data (mq_push_data),
        .pop       (mq_pop),
        .head_data (mq_head),
        .count     (mq_count)
    );

    // Back end moves only when the result queue has room for the judge stage
    assign mq_pop = (mq_count != '0) &&
                    ((FB'(oq_count) + FB'(res_valid)) < FB'(DEPTH));

    ssed_back #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CB          (CB),
        .WB          (WB),
        .HB          (HB),
        .QW          (QW),
        .OW          (OW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .w_cfg     (w_reg),
        .h_cfg     (h_reg),
        .restart   (cfg_write),
        .take      (mq_pop),
        .q_data    (mq_head),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    ssed_fifo #(
        .WIDTH (OW),
        .DEPTH (DEPTH)
    ) u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res_data),
        .pop       (oq_pop),
        .head_data (oq_head),
        .count     (oq_count)
    );

    // Result side
    assign empty       = oq_count == '0;
    assign oq_pop      = pop && !empty;
    assign pixel_row   = oq_head[OW-1 -: ROWB];
    assign pixel_col   = oq_head[COLB+1 : 2];
    assign is_extremum = oq_head[1];
    assign frame_done  = oq_head[0];

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int MAX_W     = 2048;
    localparam int MAX_H     = 4096;
    localparam int LIMIT     = 2000000;
    localparam int DRAIN_CYC = 32;

    typedef struct {
        logic [ssed_pkg::ROW_OUT_BITS-1:0] row;
        logic [ssed_pkg::COL_OUT_BITS-1:0] col;
        logic                              ext;
        logic                              done;
    } detection_t;

    // Tracks the window and line history and predicts each detection
    class extremum_scoreboard;
        logic signed [15:0] lines [MAX_W][2][3];
        logic signed [15:0] win [3][3][3];
        int unsigned        in_row, in_col, out_row, out_col;
        int unsigned        fw, fh;
        detection_t         pending [$];
        int                 errors;

        function new();
            foreach (lines[i, j, k]) lines[i][j][k] = '0;
            foreach (win[i, j, k]) win[i][j][k] = '0;
            fw = ssed_pkg::WIDTH_RESET;
            fh = ssed_pkg::HEIGHT_RESET;
            errors = 0;
            restart();
        endfunction

        function void restart();
            in_row = 0;
            in_col = 0;
            out_row = 0;
            out_col = 0;
        endfunction

        function int unsigned eff_dim(int unsigned v, int unsigned lim);
            if (v == 0)
            begin
                return 1;
            end
            return (v > lim) ? lim : v;
        endfunction

        function void write_reg(logic [ssed_pkg::CFG_INDEX_BITS-1:0] idx,
                                logic [ssed_pkg::CFG_DATA_BITS-1:0] val);
            if (idx == ssed_pkg::REG_FRAME_WIDTH)
            begin
                fw = val[ssed_pkg::CFG_WIDTH_BITS-1:0];
            end
            else
            begin
                fh = val;
            end
            restart();
        endfunction

        function void note_input(logic m, logic signed [15:0] lo, logic signed [15:0] cu,
                                 logic signed [15:0] up);
            int unsigned        w, h, c;
            bit                 in_frame, emit, no_gt, no_lt, done;
            logic signed [15:0] fresh [3];
            logic signed [15:0] center, v;
            int                 r0, r1, k0, k1;
            detection_t         d;
            w = eff_dim(fw, MAX_W);
            h = eff_dim(fh, MAX_H);
            in_frame = in_row < h;
            if (m && in_frame)
            begin
                return;
            end
            fresh[0] = in_frame ? lo : 16'sd0;
            fresh[1] = in_frame ? cu : 16'sd0;
            fresh[2] = in_frame ? up : 16'sd0;
            c = in_col;
            // shift window one column and pull the new column from the line history
            for (int l = 0; l < 3; l++)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win[l][r][0] = win[l][r][1];
                    win[l][r][1] = win[l][r][2];
                end
                win[l][0][2] = lines[c][0][l];
                win[l][1][2] = lines[c][1][l];
                lines[c][0][l] = lines[c][1][l];
                lines[c][1][l] = fresh[l];
                win[l][2][2] = fresh[l];
            end
            emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
            if (!emit)
            begin
                return;
            end
            // clipped 3x3x3 comparison around the center
            center = win[1][1][1];
            no_gt = 1;
            no_lt = 1;
            r0 = (out_row >= 1) ? 0 : 1;
            r1 = (out_row + 1 < h) ? 2 : 1;
            k0 = (out_col >= 1) ? 0 : 1;
            k1 = (out_col + 1 < w) ? 2 : 1;
            for (int l = 0; l < 3; l++)
            begin
                for (int r = r0; r <= r1; r++)
                begin
                    for (int k = k0; k <= k1; k++)
                    begin
                        v = win[l][r][k];
                        if (v > center) no_gt = 0;
                        if (v < center) no_lt = 0;
                    end
                end
            end
            done = (out_row == h - 1) && (out_col == w - 1);
            d.row = out_row[ssed_pkg::ROW_OUT_BITS-1:0];
            d.col = out_col[ssed_pkg::COL_OUT_BITS-1:0];
            d.ext = no_gt || no_lt;
            d.done = done;
            pending.push_back(d);
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
            if (done)
            begin
                restart();
            end
        endfunction

        function void check_result(detection_t got);
            detection_t exp_d;
            if (pending.size() == 0)
            begin
                $error("unexpected detection row %0d col %0d", got.row, got.col);
                errors++;
                return;
            end
            exp_d = pending.pop_front();
            if (got.row !== exp_d.row)
            begin
                $error("pixel_row: expected %0d, got %0d", exp_d.row, got.row);
                errors++;
            end
            if (got.col !== exp_d.col)
            begin
                $error("pixel_col: expected %0d, got %0d", exp_d.col, got.col);
                errors++;
            end
            if (got.ext !== exp_d.ext)
            begin
                $error("is_extremum: expected %0d, got %0d", exp_d.ext, got.ext);
                errors++;
            end
            if (got.done !== exp_d.done)
            begin
                $error("frame_done: expected %0d, got %0d", exp_d.done, got.done);
                errors++;
            end
        endfunction
    endclass

    logic                                clk = 0;
    logic                                rst_n = 0;
    logic                                cfg_write = 0;
    logic [ssed_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [ssed_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                                push = 0;
    logic                                full;
    logic                                mode = 0;
    logic signed [15:0]                  lower_sample = '0;
    logic signed [15:0]                  current_sample = '0;
    logic signed [15:0]                  upper_sample = '0;
    logic                                empty;
    logic                                pop = 0;
    logic [ssed_pkg::ROW_OUT_BITS-1:0]   pixel_row;
    logic [ssed_pkg::COL_OUT_BITS-1:0]   pixel_col;
    logic                                is_extremum;
    logic                                frame_done;

    extremum_scoreboard sb = new();
    int                 cycles = 0;
    int                 burst_left = 0;
    int                 pop_pct = 100;

    scale_space_extremum_detector dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .push(push), .full(full), .mode(mode),
        .lower_sample(lower_sample), .current_sample(current_sample),
        .upper_sample(upper_sample),
        .empty(empty), .pop(pop),
        .pixel_row(pixel_row), .pixel_col(pixel_col),
        .is_extremum(is_extremum), .frame_done(frame_done)
    );

    always #10 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side: check accepted beats, stall on a shifting pattern
    always @(posedge clk)
    begin
        detection_t got;
        if (rst_n && pop && !empty)
        begin
            got.row = pixel_row;
            got.col = pixel_col;
            got.ext = is_extremum;
            got.done = frame_done;
            sb.check_result(got);
        end
        if (cycles % 97 == 0)
        begin
            case ($urandom_range(0, 3))
                0: pop_pct = 100;
                1: pop_pct = 60;
                2: pop_pct = 25;
                default: pop_pct = 90;
            endcase
        end
        pop <= ($urandom_range(0, 99) < pop_pct);
    end

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 4))
            0, 1: return 16'($urandom);
            2: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            default: return $signed(16'($urandom_range(0, 4))) - 16'sd2;
        endcase
    endfunction

    // One beat on the input side, with bursts and gaps
    task automatic send_beat(logic m, logic signed [15:0] lo, logic signed [15:0] cu,
                             logic signed [15:0] up);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                push <= 0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        push <= 1;
        mode <= m;
        lower_sample <= lo;
        current_sample <= cu;
        upper_sample <= up;
        do @(posedge clk); while (full);
        sb.note_input(m, lo, cu, up);
    endtask

    task automatic send_random_pixel();
        send_beat(0, pick_sample(), pick_sample(), pick_sample());
    endtask

    // Full frame plus drain; some in-frame flush noise, some drain beats as pixels
    task automatic run_frame(int unsigned w, int unsigned h);
        for (int unsigned i = 0; i < w * h; i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                send_beat(1, pick_sample(), pick_sample(), pick_sample());
            end
            send_random_pixel();
        end
        for (int unsigned i = 0; i <= w; i++)
        begin
            send_beat($urandom_range(0, 2) != 0, pick_sample(), pick_sample(),
                      pick_sample());
        end
    endtask

    // Register write while the block is idle
    task automatic write_reg(logic [ssed_pkg::CFG_INDEX_BITS-1:0] idx, int unsigned val);
        push <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= val[ssed_pkg::CFG_DATA_BITS-1:0];
        @(posedge clk);
        cfg_write <= 0;
        sb.write_reg(idx, val[ssed_pkg::CFG_DATA_BITS-1:0]);
    endtask

    task automatic run_phase(int unsigned wr, int unsigned hr, int frames);
        write_reg(ssed_pkg::REG_FRAME_WIDTH, wr);
        write_reg(ssed_pkg::REG_FRAME_HEIGHT, hr);
        for (int f = 0; f < frames; f++)
        begin
            run_frame(sb.eff_dim(sb.fw, MAX_W), sb.eff_dim(sb.fh, MAX_H));
        end
    endtask

    // Start of a frame too large to finish; the next write restarts it
    task automatic run_partial(int unsigned wr, int unsigned hr, int n);
        write_reg(ssed_pkg::REG_FRAME_WIDTH, wr);
        write_reg(ssed_pkg::REG_FRAME_HEIGHT, hr);
        for (int i = 0; i < n; i++)
        begin
            send_random_pixel();
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed 3x3 frame: plateau, extremes of the sample range, flush noise
        write_reg(ssed_pkg::REG_FRAME_WIDTH, 3);
        write_reg(ssed_pkg::REG_FRAME_HEIGHT, 3);
        send_beat(1, 16'sh1234, 16'sh1234, 16'sh1234);
        for (int i = 0; i < 9; i++)
        begin
            case (i)
                0: send_beat(0, 16'sh8000, 16'sh7fff, 16'sh8000);
                4: send_beat(0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
                5: send_beat(1, 16'sh7fff, 16'sh0000, 16'sh8000);
                default: send_beat(0, 16'sh0000, 16'sh0000, 16'sh0000);
            endcase
        end
        send_beat(1, 16'sh0, 16'sh0, 16'sh0);
        send_beat(0, 16'shffff, 16'shffff, 16'shffff);
        send_beat(1, 16'sh0, 16'sh0, 16'sh0);
        send_beat(0, 16'sh5555, 16'shaaaa, 16'sh0001);

        // Size extremes: zero acts as one, oversize acts as the maximum
        run_phase(0, 0, 2);
        run_phase(1, 5, 2);
        run_phase(5, 1, 2);
        run_partial(4095, 2, 30);
        run_partial(1, 8191, 30);
        run_phase(2, 2, 2);
        // Width field keeps only its low bits
        run_phase(13'h1003, 4, 1);

        // Random bulk on small frames
        run_phase(8, 6, 2);
        run_phase(5, 7, 1);
        run_phase(13, 4, 2);

        push <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
sv/ssed_pkg.sv
sv/ssed_fifo.sv
sv/ssed_front.sv
sv/ssed_back.sv
sv/scale_space_extremum_detector.sv
verif/tb.sv
